// ----- rtl/best_fit_implicit_list_allocator_unit_defines.svh -----
// Assertion macros used by the allocator top level.
`ifndef BEST_FIT_IMPLICIT_LIST_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_IMPLICIT_LIST_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFILA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFILA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bfila_pkg.sv -----
package bfila_pkg;

  localparam int unsigned MAX_POOL_BYTES = 4096;
  localparam int unsigned HEADER_BYTES   = 4;
  localparam int unsigned POOL_RESET     = 4096;
  localparam int unsigned POOL_MIN       = 8;
  localparam int unsigned ADDR_W         = 12;   // header store index, byte offset
  localparam int unsigned HDR_W          = 14;   // signed header value
  localparam int unsigned LIM_W          = 13;   // pool limit, up to MAX_POOL_BYTES
  localparam int unsigned CFG_W          = 13;
  localparam int unsigned HDR_MAX        = 8191;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    POS_HOLD,
    POS_ZERO,   // restart the walk, reload best candidate
    POS_STEP,   // advance over the header in the read register
    POS_SKIP    // advance over the header held for a merge check
  } pos_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_POS,
    RD_NXT,
    RD_AT
  } rd_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_INIT,
    WR_SPLIT,
    WR_USED,
    WR_FREE,
    WR_MERGE
  } wr_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_FAIL,
    RES_GRANT
  } res_e;

  typedef struct packed {
    logic latch;
    logic best_upd;
    pos_e pos_op;
    rd_e  rd_sel;
    wr_e  wr_sel;
    res_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_zero;
    logic off_ok;
    logic pos_in;
    logic fit;
    logic link_ok;
    logic merge_ok;
  } stat_t;

endpackage

// ----- rtl/bfila_dpath.sv -----
module bfila_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pool_bytes_we_i,
  input  logic [bfila_pkg::CFG_W-1:0]         pool_bytes_i,
  input  logic [bfila_pkg::ADDR_W-1:0]        request_size_i,
  input  logic [bfila_pkg::ADDR_W-1:0]        payload_offset_i,
  input  bfila_pkg::cmd_t                     cmd_i,
  output bfila_pkg::stat_t                    stat_o,
  output logic                                status_o,
  output logic [bfila_pkg::ADDR_W-1:0]        granted_offset_o
);

  localparam int unsigned AW = bfila_pkg::ADDR_W;
  localparam int unsigned HW = bfila_pkg::HDR_W;
  localparam int unsigned LW = bfila_pkg::LIM_W;

  logic [HW-1:0] mem [bfila_pkg::MAX_POOL_BYTES];

  logic [bfila_pkg::CFG_W-1:0] pool_q;
  logic [AW-1:0]               clr_cnt_q;
  logic [HW-1:0]               rdata_q;
  logic [HW-1:0]               pos_q, pos_d;
  logic [HW-1:0]               best_q;
  logic [AW-1:0]               best_at_q;
  logic [HW-1:0]               h_q;
  logic [AW-1:0]               req_q;
  logic [AW-1:0]               at_q;
  logic                        status_q;
  logic [AW-1:0]               grant_q;

  logic [LW-1:0]   lim;
  logic [HW-1:0]   lim_w;
  logic [HW-1:0]   hmag, step, pos_next, skip_pos;
  logic [LW-1:0]   need;
  logic signed [HW:0] h_s, best_s, need_s, lim_s;
  logic            hit, hpos, npos;
  logic [HW:0]     sum;
  logic [HW-1:0]   sum_sat;
  logic [HW-1:0]   split_addr, split_data, used_data, free_data, init_data;
  logic [AW-1:0]   off_at;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [HW-1:0]   wdata;

  // Pool size is used saturated to the legal range.
  always_comb begin
    if (pool_q < LW'(bfila_pkg::POOL_MIN)) begin
      lim = LW'(bfila_pkg::POOL_MIN);
    end else if (pool_q > LW'(bfila_pkg::MAX_POOL_BYTES)) begin
      lim = LW'(bfila_pkg::MAX_POOL_BYTES);
    end else begin
      lim = LW'(pool_q);
    end
  end
  assign lim_w = HW'(lim);

  assign hmag     = rdata_q[HW-1] ? (~rdata_q + HW'(1)) : rdata_q;
  assign step     = hmag + HW'(bfila_pkg::HEADER_BYTES);
  assign pos_next = pos_q + step;
  assign skip_pos = pos_q + h_q + HW'(bfila_pkg::HEADER_BYTES);

  assign need   = LW'(req_q) + LW'(bfila_pkg::HEADER_BYTES);
  assign h_s    = $signed({rdata_q[HW-1], rdata_q});
  assign best_s = $signed({best_q[HW-1], best_q});
  assign need_s = $signed((HW+1)'(need));
  assign lim_s  = $signed((HW+1)'(lim));
  assign hit    = (h_s > need_s) && (h_s < best_s);

  assign hpos    = !rdata_q[HW-1] && (rdata_q != '0);
  assign npos    = hpos;
  assign sum     = (HW+1)'(h_q) + (HW+1)'(bfila_pkg::HEADER_BYTES) + (HW+1)'(rdata_q);
  assign sum_sat = (sum > (HW+1)'(bfila_pkg::HDR_MAX)) ? HW'(bfila_pkg::HDR_MAX) : sum[HW-1:0];

  assign split_addr = HW'(best_at_q) + HW'(bfila_pkg::HEADER_BYTES) + HW'(req_q);
  assign split_data = best_q - HW'(req_q) - HW'(bfila_pkg::HEADER_BYTES);
  assign used_data  = HW'(0) - HW'(req_q);
  assign free_data  = (hmag > HW'(bfila_pkg::HDR_MAX)) ? HW'(bfila_pkg::HDR_MAX) : hmag;
  assign init_data  = lim_w - HW'(bfila_pkg::HEADER_BYTES);
  assign off_at     = payload_offset_i - AW'(bfila_pkg::HEADER_BYTES);

  always_comb begin
    stat_o.clr_last = (clr_cnt_q == '1);
    stat_o.req_zero = (request_size_i == '0);
    stat_o.off_ok   = (payload_offset_i >= AW'(bfila_pkg::HEADER_BYTES)) &&
                      (LW'(off_at) < lim);
    stat_o.pos_in   = (pos_q < lim_w);
    stat_o.fit      = (best_s < lim_s);
    stat_o.link_ok  = hpos && (pos_next < lim_w);
    stat_o.merge_ok = npos && (sum_sat > h_q);
  end

  always_comb begin
    we    = 1'b1;
    waddr = '0;
    wdata = '0;
    case (cmd_i.wr_sel)
      bfila_pkg::WR_CLEAR: begin
        waddr = clr_cnt_q;
        wdata = (clr_cnt_q == '0) ?
                HW'(bfila_pkg::POOL_RESET - bfila_pkg::HEADER_BYTES) : '0;
      end
      bfila_pkg::WR_INIT: begin
        wdata = init_data;
      end
      bfila_pkg::WR_SPLIT: begin
        // The remainder header is dropped when it would land past the store.
        we    = (split_addr < HW'(bfila_pkg::MAX_POOL_BYTES));
        waddr = split_addr[AW-1:0];
        wdata = split_data;
      end
      bfila_pkg::WR_USED: begin
        waddr = best_at_q;
        wdata = used_data;
      end
      bfila_pkg::WR_FREE: begin
        waddr = at_q;
        wdata = free_data;
      end
      bfila_pkg::WR_MERGE: begin
        waddr = pos_q[AW-1:0];
        wdata = sum_sat;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      bfila_pkg::RD_POS: raddr = pos_q[AW-1:0];
      bfila_pkg::RD_NXT: raddr = pos_next[AW-1:0];
      bfila_pkg::RD_AT:  raddr = at_q;
      default:           raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_sel != bfila_pkg::RD_NONE) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    case (cmd_i.pos_op)
      bfila_pkg::POS_ZERO: pos_d = '0;
      bfila_pkg::POS_STEP: pos_d = pos_next;
      bfila_pkg::POS_SKIP: pos_d = skip_pos;
      default:             pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.pos_op == bfila_pkg::POS_ZERO) begin
      best_q <= lim_w;
    end else if (cmd_i.best_upd && hit) begin
      best_q    <= rdata_q;
      best_at_q <= pos_q[AW-1:0];
    end
    if (cmd_i.rd_sel == bfila_pkg::RD_NXT) begin
      h_q <= rdata_q;
    end
    if (cmd_i.latch) begin
      req_q <= request_size_i;
      at_q  <= off_at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q    <= bfila_pkg::CFG_W'(bfila_pkg::POOL_RESET);
      clr_cnt_q <= '0;
      status_q  <= 1'b0;
      grant_q   <= '0;
    end else begin
      if (pool_bytes_we_i) begin
        pool_q <= pool_bytes_i;
      end
      if (cmd_i.wr_sel == bfila_pkg::WR_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      case (cmd_i.res_sel)
        bfila_pkg::RES_OK: begin
          status_q <= 1'b0;
          grant_q  <= '0;
        end
        bfila_pkg::RES_FAIL: begin
          status_q <= 1'b1;
          grant_q  <= '0;
        end
        bfila_pkg::RES_GRANT: begin
          status_q <= 1'b0;
          grant_q  <= best_at_q + AW'(bfila_pkg::HEADER_BYTES);
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o         = status_q;
  assign granted_offset_o = grant_q;

endmodule

// ----- rtl/bfila_ctrl.sv -----
module bfila_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       command_i,
  input  bfila_pkg::stat_t stat_i,
  output bfila_pkg::cmd_t  cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_EV  = 4'd3;
  localparam logic [3:0] S_A_SPL = 4'd4;
  localparam logic [3:0] S_A_USE = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_WR  = 4'd7;
  localparam logic [3:0] S_W_RD  = 4'd8;
  localparam logic [3:0] S_W_EV  = 4'd9;
  localparam logic [3:0] S_W_NX  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.latch    = 1'b0;
    cmd_o.best_upd = 1'b0;
    cmd_o.pos_op   = bfila_pkg::POS_HOLD;
    cmd_o.rd_sel   = bfila_pkg::RD_NONE;
    cmd_o.wr_sel   = bfila_pkg::WR_NONE;
    cmd_o.res_sel  = bfila_pkg::RES_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_sel = bfila_pkg::WR_CLEAR;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DONE;
          case (command_i)
            bfila_pkg::CMD_INIT: begin
              cmd_o.wr_sel  = bfila_pkg::WR_INIT;
              cmd_o.res_sel = bfila_pkg::RES_OK;
            end
            bfila_pkg::CMD_ALLOC: begin
              if (stat_i.req_zero) begin
                cmd_o.res_sel = bfila_pkg::RES_FAIL;
              end else begin
                cmd_o.pos_op = bfila_pkg::POS_ZERO;
                state_d      = S_A_RD;
              end
            end
            bfila_pkg::CMD_FREE: begin
              if (stat_i.off_ok) begin
                state_d = S_F_RD;
              end else begin
                cmd_o.res_sel = bfila_pkg::RES_OK;
              end
            end
            default: begin
              cmd_o.res_sel = bfila_pkg::RES_OK;
            end
          endcase
        end
      end
      S_A_RD: begin
        if (stat_i.pos_in) begin
          cmd_o.rd_sel = bfila_pkg::RD_POS;
          state_d      = S_A_EV;
        end else if (stat_i.fit) begin
          state_d = S_A_SPL;
        end else begin
          cmd_o.res_sel = bfila_pkg::RES_FAIL;
          state_d       = S_DONE;
        end
      end
      S_A_EV: begin
        cmd_o.best_upd = 1'b1;
        cmd_o.pos_op   = bfila_pkg::POS_STEP;
        state_d        = S_A_RD;
      end
      S_A_SPL: begin
        cmd_o.wr_sel = bfila_pkg::WR_SPLIT;
        state_d      = S_A_USE;
      end
      S_A_USE: begin
        cmd_o.wr_sel  = bfila_pkg::WR_USED;
        cmd_o.res_sel = bfila_pkg::RES_GRANT;
        state_d       = S_DONE;
      end
      S_F_RD: begin
        cmd_o.rd_sel = bfila_pkg::RD_AT;
        state_d      = S_F_WR;
      end
      S_F_WR: begin
        cmd_o.wr_sel = bfila_pkg::WR_FREE;
        cmd_o.pos_op = bfila_pkg::POS_ZERO;
        state_d      = S_W_RD;
      end
      S_W_RD: begin
        if (stat_i.pos_in) begin
          cmd_o.rd_sel = bfila_pkg::RD_POS;
          state_d      = S_W_EV;
        end else begin
          cmd_o.res_sel = bfila_pkg::RES_OK;
          state_d       = S_DONE;
        end
      end
      S_W_EV: begin
        if (stat_i.link_ok) begin
          cmd_o.rd_sel = bfila_pkg::RD_NXT;
          state_d      = S_W_NX;
        end else begin
          cmd_o.pos_op = bfila_pkg::POS_STEP;
          state_d      = S_W_RD;
        end
      end
      S_W_NX: begin
        // A successful merge rereads the same header, so chains collapse.
        if (stat_i.merge_ok) begin
          cmd_o.wr_sel = bfila_pkg::WR_MERGE;
        end else begin
          cmd_o.pos_op = bfila_pkg::POS_SKIP;
        end
        state_d = S_W_RD;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ----- rtl/best_fit_implicit_list_allocator_unit.sv -----
// Init, unknown and rejected commands go straight from idle to the result beat; allocate
// walks every header, then splits and marks the best block (or fails); free reads its
// header, writes it free, then walks the pool merging runs (a merge rereads its header).
// One command at a time: a new one is taken only after the result beat. No result stall exists.
// Reset (rst_ni low, asynchronous) clears control state, then a clearing pass
// rewrites every header store entry while busy_o stays high; config writes still land.
`include "best_fit_implicit_list_allocator_unit_defines.svh"

module best_fit_implicit_list_allocator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: pool size in bytes, headers included.
  input  logic                         pool_bytes_we_i,
  input  logic [bfila_pkg::CFG_W-1:0]  pool_bytes_i,
  // Command beat.
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   command_i,
  input  logic [bfila_pkg::ADDR_W-1:0] request_size_i,
  input  logic [bfila_pkg::ADDR_W-1:0] payload_offset_i,
  // Result beat, valid for the single cycle that done_o is high.
  output logic                         done_o,
  output logic                         status_o,
  output logic [bfila_pkg::ADDR_W-1:0] granted_offset_o
);

  // The controller sequences every command as a short program of header
  // reads and writes. The datapath owns the header store, the walk pointer,
  // the best-fit candidate and the result register, and it reports the
  // comparisons that steer the controller back as one status struct.
  bfila_pkg::cmd_t  cmd;
  bfila_pkg::stat_t stat;

  bfila_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy_o),
    .done_o    (done_o)
  );

  // The header store is addressed by byte offset. Walks step from one header
  // to the next by the header size plus the magnitude of the stored size, so
  // each visited header passes through a read state and an evaluate state.
  bfila_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pool_bytes_we_i  (pool_bytes_we_i),
    .pool_bytes_i     (pool_bytes_i),
    .request_size_i   (request_size_i),
    .payload_offset_i (payload_offset_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o)
  );

  // A result beat only appears while a command is in flight, is a single
  // cycle wide, and a failed allocation never carries an offset.
  `BFILA_ASSERT_NOW(a_done_in_busy, clk_i, rst_ni, done_o, busy_o, "result beat while idle")
  `BFILA_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o && !busy_o, "result beat repeated")
  `BFILA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accept did not go busy")
  `BFILA_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, done_o && status_o, granted_offset_o == '0, "failure with offset")

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

  // Codes and limits used by the allocator model below. The fourth command
  // code is not decoded by the block and must leave the pool untouched.
  localparam logic [1:0] CMD_BOGUS   = 2'd3;
  localparam logic       ST_OK       = 1'b0;
  localparam logic       ST_NOFIT    = 1'b1;
  localparam int         HDR_SZ      = bfila_pkg::HEADER_BYTES;
  localparam int         STORE_DEPTH = bfila_pkg::MAX_POOL_BYTES;
  localparam int         HDR_TOP     = bfila_pkg::HDR_MAX;
  localparam int         HDR_BOTTOM  = -8192;
  localparam int         NUM_PHASES  = 16;
  localparam int         MAX_REPORTS = 10;

  // One entry of the command queue: either a pool resize or a command beat.
  typedef struct {
    logic                         is_resize;
    logic [bfila_pkg::CFG_W-1:0]  pool_size;
    logic [1:0]                   cmd;
    logic [bfila_pkg::ADDR_W-1:0] req;
    logic [bfila_pkg::ADDR_W-1:0] off;
  } alloc_item_t;

  // What one result beat is supposed to carry.
  typedef struct {
    logic                         status;
    logic [bfila_pkg::ADDR_W-1:0] offset;
  } outcome_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         pool_bytes_we_i = 1'b0;
  logic [bfila_pkg::CFG_W-1:0]  pool_bytes_i = '0;
  logic                         start_i = 1'b0;
  logic                         busy_o;
  logic [1:0]                   command_i = '0;
  logic [bfila_pkg::ADDR_W-1:0] request_size_i = '0;
  logic [bfila_pkg::ADDR_W-1:0] payload_offset_i = '0;
  logic                         done_o;
  logic                         status_o;
  logic [bfila_pkg::ADDR_W-1:0] granted_offset_o;

  best_fit_implicit_list_allocator_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pool_bytes_we_i  (pool_bytes_we_i),
    .pool_bytes_i     (pool_bytes_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .command_i        (command_i),
    .request_size_i   (request_size_i),
    .payload_offset_i (payload_offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_offset_o (granted_offset_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the header store and the pool size register. Headers are
  // 14-bit signed values addressed by byte offset, exactly as in the block.
  logic signed [bfila_pkg::HDR_W-1:0] hdr_mem [STORE_DEPTH];
  logic [bfila_pkg::CFG_W-1:0]        pool_reg;

  // Payload offsets that the shadow pool currently holds as granted. The
  // stimulus draws most of its frees from here so that the pool fills,
  // fragments and coalesces instead of just rejecting bogus offsets.
  int          live_offsets[$];
  alloc_item_t command_q[$];
  outcome_t    outcome_q[$];
  int          accepted_cnt = 0;
  int          mismatch_cnt = 0;

  // The configured size is used saturated to the legal range of the pool.
  function automatic int pool_limit();
    if (pool_reg < bfila_pkg::POOL_MIN) return bfila_pkg::POOL_MIN;
    if (pool_reg > bfila_pkg::MAX_POOL_BYTES) return STORE_DEPTH;
    return int'(pool_reg);
  endfunction

  // Reads outside the store return an empty header.
  function automatic int hdr_get(int at);
    if (at >= STORE_DEPTH) return 0;
    return int'(hdr_mem[at]);
  endfunction

  // Writes saturate to the header range and are dropped past the store.
  function automatic void hdr_put(int at, int v);
    if (v > HDR_TOP) v = HDR_TOP;
    if (v < HDR_BOTTOM) v = HDR_BOTTOM;
    if (at < STORE_DEPTH) hdr_mem[at] = v[bfila_pkg::HDR_W-1:0];
  endfunction

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Best fit: the smallest free block strictly larger than the request plus
  // one header wins; the first such block found wins a tie. The remainder
  // becomes a new free block right behind the granted payload.
  function automatic outcome_t pool_allocate(int req);
    int       lim;
    int       pos;
    int       best;
    int       best_at;
    int       need;
    int       h;
    int       grant;
    outcome_t res;
    lim        = pool_limit();
    pos        = 0;
    best       = lim;
    best_at    = 0;
    need       = req + HDR_SZ;
    res.status = ST_NOFIT;
    res.offset = '0;
    if (req == 0) return res;
    while (pos < lim) begin
      h = hdr_get(pos);
      if (h > need && h < best) begin
        best    = h;
        best_at = pos;
      end
      pos += HDR_SZ + magnitude(h);
    end
    if (best >= lim) return res;
    hdr_put(best_at + HDR_SZ + req, best - req - HDR_SZ);
    hdr_put(best_at, -req);
    grant      = best_at + HDR_SZ;
    res.status = ST_OK;
    res.offset = grant[bfila_pkg::ADDR_W-1:0];
    return res;
  endfunction

  // Release marks the header free, then one walk over the whole pool folds
  // every run of free blocks into its first block. A merge is retried at the
  // same position so that longer runs collapse completely.
  function automatic void pool_release(int off);
    int lim;
    int pos;
    int at;
    int h;
    int nxt;
    int n;
    int sum;
    bit merged;
    lim = pool_limit();
    pos = 0;
    if (off < HDR_SZ) return;
    at = off - HDR_SZ;
    if (at >= lim) return;
    hdr_put(at, magnitude(hdr_get(at)));
    while (pos < lim) begin
      h      = hdr_get(pos);
      merged = 1'b0;
      if (h > 0) begin
        nxt = pos + HDR_SZ + h;
        if (nxt < lim) begin
          n = hdr_get(nxt);
          if (n > 0) begin
            sum = h + HDR_SZ + n;
            if (sum > HDR_TOP) sum = HDR_TOP;
            if (sum > h) begin
              hdr_put(pos, sum);
              merged = 1'b1;
            end
          end
        end
      end
      if (!merged) pos += HDR_SZ + magnitude(h);
    end
  endfunction

  // Applies one accepted command to the shadow pool and returns the beat it
  // must produce. The list of live offsets follows the same command.
  function automatic outcome_t run_command(logic [1:0] cmd, int req, int off);
    outcome_t res;
    int       k;
    res.status = ST_OK;
    res.offset = '0;
    case (cmd)
      bfila_pkg::CMD_INIT: begin
        hdr_put(0, pool_limit() - HDR_SZ);
        live_offsets.delete();
      end
      bfila_pkg::CMD_ALLOC: begin
        res = pool_allocate(req);
        if (res.status == ST_OK) live_offsets.push_back(int'(res.offset));
      end
      bfila_pkg::CMD_FREE: begin
        pool_release(off);
        for (k = 0; k < live_offsets.size(); k++) begin
          if (live_offsets[k] == off) begin
            live_offsets.delete(k);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic void queue_command(logic [1:0] cmd, int req, int off);
    alloc_item_t it;
    it.is_resize = 1'b0;
    it.pool_size = '0;
    it.cmd       = cmd;
    it.req       = req[bfila_pkg::ADDR_W-1:0];
    it.off       = off[bfila_pkg::ADDR_W-1:0];
    command_q.push_back(it);
  endfunction

  // The sender holds back a ready beat 18 percent of the time for the first stretch of the
  // run, 62 percent of the time for the second, and never for the rest.
  function automatic int idle_pct();
    if (accepted_cnt < 400) return 18;
    if (accepted_cnt < 800) return 62;
    return 0;
  endfunction

  // Driver. The head of the command queue is only popped once its beat has
  // been accepted, or once its pool write has landed, so the stimulus side
  // can tell from an empty queue that the shadow pool is up to date.
  // A pool resize waits until no beat is outstanding and the block is idle.
  logic        drv_start;
  logic        drv_we;
  alloc_item_t drv_item;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i         <= 1'b0;
      pool_bytes_we_i <= 1'b0;
    end else begin
      drv_start = start_i;
      drv_we    = 1'b0;
      if (pool_bytes_we_i) begin
        pool_reg = pool_bytes_i;
        void'(command_q.pop_front());
      end
      if (start_i && !busy_o) begin
        outcome_q.push_back(run_command(command_i, int'(request_size_i),
                                        int'(payload_offset_i)));
        void'(command_q.pop_front());
        accepted_cnt++;
        drv_start = 1'b0;
      end
      // A beat that is still waiting keeps start high and its fields steady.
      if (!drv_start && command_q.size() != 0) begin
        drv_item = command_q[0];
        if (drv_item.is_resize) begin
          // The done check keeps this independent of when the monitor pops.
          if (!pool_bytes_we_i && !busy_o && !done_o && outcome_q.size() == 0) begin
            drv_we       = 1'b1;
            pool_bytes_i <= drv_item.pool_size;
          end
        end else if ($urandom_range(99) >= idle_pct()) begin
          drv_start        = 1'b1;
          command_i        <= drv_item.cmd;
          request_size_i   <= drv_item.req;
          payload_offset_i <= drv_item.off;
        end
      end
      start_i         <= drv_start;
      pool_bytes_we_i <= drv_we;
    end
  end

  // Monitor. Every command yields exactly one beat, in order, and the
  // receiver cannot push back, so each done cycle retires the oldest entry.
  outcome_t mon_want;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result beat: status %0d offset %0d",
                   status_o, granted_offset_o);
      end else begin
        mon_want = outcome_q.pop_front();
        if (status_o !== mon_want.status || granted_offset_o !== mon_want.offset) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("result mismatch: status exp %0d got %0d, offset exp %0d got %0d",
                     mon_want.status, status_o, mon_want.offset, granted_offset_o);
        end
      end
    end
  end

  // Pool sizes visited by the random phases. They include both saturation
  // cases and the smallest pool, in which no allocation can ever fit. The
  // last slot is drawn at run time.
  logic [bfila_pkg::CFG_W-1:0] phase_pool [NUM_PHASES] = '{
    13'd64, 13'd8191, 13'd8, 13'd160, 13'd4, 13'd300, 13'd4096, 13'd96,
    13'd512, 13'd0, 13'd200, 13'd1000, 13'd2100, 13'd40, 13'd128, 13'd64
  };

  initial begin : stimulus
    int          p;
    int          i;
    int          k;
    int          lim;
    int          n_items;
    int          req;
    int          off;
    int          sel;
    alloc_item_t it;

    // Shadow state after reset: an empty store, then one free block that
    // spans the default pool.
    for (k = 0; k < STORE_DEPTH; k++) hdr_mem[k] = '0;
    pool_reg = bfila_pkg::CFG_W'(bfila_pkg::POOL_RESET);
    hdr_put(0, pool_limit() - HDR_SZ);

    // Directed part in the default pool. A zero request, an all-ones request
    // and a request that fills the whole block exactly all have to fail,
    // since the fitting block must be strictly larger than request plus
    // header. Frees below the first payload exercise the rejection of bad offsets; a far-end
    // free still lies inside the pool and is taken, and the undecoded command must be a no-op.
    queue_command(bfila_pkg::CMD_ALLOC, 0, 4095);
    queue_command(bfila_pkg::CMD_ALLOC, 4095, 0);
    queue_command(bfila_pkg::CMD_ALLOC, 4092, 0);
    queue_command(bfila_pkg::CMD_ALLOC, 4087, 0);
    queue_command(bfila_pkg::CMD_ALLOC, 1, 0);
    queue_command(bfila_pkg::CMD_FREE, 0, 4);
    queue_command(CMD_BOGUS, 4095, 4095);
    queue_command(bfila_pkg::CMD_FREE, 4095, 0);
    queue_command(bfila_pkg::CMD_FREE, 0, 3);
    queue_command(bfila_pkg::CMD_FREE, 0, 4095);
    queue_command(bfila_pkg::CMD_INIT, 0, 0);
    // Carve a few blocks, punch a hole, and check that a small request lands
    // in the hole rather than in the large tail. Then free around the hole
    // so that neighbors coalesce.
    queue_command(bfila_pkg::CMD_ALLOC, 100, 0);
    queue_command(bfila_pkg::CMD_ALLOC, 200, 0);
    queue_command(bfila_pkg::CMD_ALLOC, 50, 0);
    queue_command(bfila_pkg::CMD_ALLOC, 1, 0);
    queue_command(bfila_pkg::CMD_FREE, 0, 108);
    queue_command(bfila_pkg::CMD_ALLOC, 40, 0);
    queue_command(bfila_pkg::CMD_FREE, 0, 4);
    queue_command(bfila_pkg::CMD_FREE, 0, 312);
    queue_command(bfila_pkg::CMD_ALLOC, 2048, 0);
    queue_command(bfila_pkg::CMD_ALLOC, 4092, 0);
    queue_command(bfila_pkg::CMD_INIT, 4095, 4095);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    p = $urandom_range(700, 9);
    phase_pool[NUM_PHASES-1] = p[bfila_pkg::CFG_W-1:0];

    for (p = 0; p < NUM_PHASES; p++) begin
      // The resize only goes out once the previous phase has fully drained.
      while (command_q.size() != 0) @(negedge clk_i);
      it.is_resize = 1'b1;
      it.pool_size = phase_pool[p];
      it.cmd       = bfila_pkg::CMD_INIT;
      it.req       = '0;
      it.off       = '0;
      command_q.push_back(it);
      // Big pools make every walk long, so they get fewer commands.
      n_items = (phase_pool[p] >= 2048) ? 40 : 80;

      // Commands are generated one at a time, after the previous one has
      // been applied to the shadow pool, so frees can target live blocks.
      for (i = 0; i < n_items; i++) begin
        while (command_q.size() != 0) @(negedge clk_i);
        lim = pool_limit();
        sel = $urandom_range(99);
        if (i == 0) begin
          // Each phase rebuilds the list for the new pool size first.
          queue_command(bfila_pkg::CMD_INIT, $urandom_range(4095), $urandom_range(4095));
        end else if (sel < 48) begin
          // Mostly requests that leave room for several blocks, some of up to the
          // whole pool, and a few arbitrary ones, zero included.
          k = $urandom_range(9);
          if (k == 0) req = $urandom_range(4095);
          else if (k < 8) req = $urandom_range((lim / 8 > 1) ? lim / 8 : 1, 1);
          else req = $urandom_range(lim, 1);
          queue_command(bfila_pkg::CMD_ALLOC, req, $urandom_range(4095));
        end else if (sel < 88) begin
          // Mostly frees of granted blocks; the rest are stale, misaligned,
          // too small or past the end of the pool.
          if (live_offsets.size() != 0 && $urandom_range(9) < 8)
            off = live_offsets[$urandom_range(live_offsets.size() - 1)];
          else if ($urandom_range(9) < 3)
            off = $urandom_range(7);
          else
            off = $urandom_range(4095);
          queue_command(bfila_pkg::CMD_FREE, $urandom_range(4095), off);
        end else if (sel < 95) begin
          queue_command(bfila_pkg::CMD_INIT, $urandom_range(4095), $urandom_range(4095));
        end else begin
          queue_command(CMD_BOGUS, $urandom_range(4095), $urandom_range(4095));
        end
      end
    end

    // Drain, then leave a margin in which a stray beat would still be seen.
    while (command_q.size() != 0 || outcome_q.size() != 0 || done_o)
      @(negedge clk_i);
    repeat (64) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[best_fit_implicit_list_allocator_unit] OK");
    end else begin
      $display("[best_fit_implicit_list_allocator_unit] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest plausible run, the reset clearing
  // pass and full-pool walks included.
  initial begin
    #150000000;
    $display("[best_fit_implicit_list_allocator_unit] ERROR");
    $finish;
  end

endmodule
